### rtl/isst_pkg.sv
// Shared types, command and status codes for the indexed sequence store.
package isst_pkg;

    localparam int ISST_CAPACITY = 16;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 5;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REM_AT    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } cmd_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        entry_count;
    } rsp_item_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // apply the held item and fill the result register
    } ctrl_t;

endpackage

### rtl/indexed_sequence_store.sv
// Top level of the indexed sequence store: controller, datapath, checks.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  cmd     | in        | cmd_valid/cmd_ready  | cmd_item: command, value, index
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_item: status, read_value, entry_count
//
// Each item is accepted and held in S_IDLE; in S_EXEC the command is applied to
// the entry array and the result register is loaded. The single execute step
// shifts the whole entry array at once; no new item is accepted until it is done.
// A result waiting in the result register does not block the next accept;
// the execute step holds only while that register is still full.
// Reset clears the entry count; the entry array is not cleared.
module indexed_sequence_store #(
    parameter int CAPACITY = isst_pkg::ISST_CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  isst_pkg::cmd_item_t cmd_item,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output isst_pkg::rsp_item_t rsp_item
);
    import isst_pkg::*;

    ctrl_t ctrl;

    // Sequence accept, execute and handoff
    isst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl)
    );

    // Hold the item, shift the entries, count and build the result
    isst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cmd_item (cmd_item),
        .rsp_item (rsp_item)
    );

    // An execute step always leaves a result behind
    a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |=> rsp_valid)
        else $error("execute step left no result");

    // Only one item in flight: accepting closes the input until executed
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("second item accepted before execution");

    // A failed command never returns data (non-read commands return zero too)
    a_fail_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_item.status != ST_OK) |-> (rsp_item.read_value == 0))
        else $error("failed command returned nonzero data");

    // Reported count never exceeds the capacity while it fits the field
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (CAPACITY >= 32 || rsp_item.entry_count <= CAPACITY))
        else $error("entry count above capacity");

endmodule

### rtl/isst_ctrl.sv
// Controller state machine: sequences accept, execute and result handoff.
module isst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output isst_pkg::ctrl_t ctrl
);
    import isst_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        ctrl.load      = 1'b0;
        ctrl.exec      = 1'b0;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait until the result register can take the new result
                if (slot_free)
                begin
                    ctrl.exec      = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

### rtl/isst_dp.sv
// Datapath: held item, shifting entry array, count and result register.
module isst_dp #(
    parameter int CAPACITY = isst_pkg::ISST_CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  isst_pkg::ctrl_t     ctrl,
    input  isst_pkg::cmd_item_t cmd_item,
    output isst_pkg::rsp_item_t rsp_item
);
    import isst_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

    cmd_item_t                 item_reg;
    rsp_item_t                 rsp_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic signed [VALUE_W-1:0] entries_reg  [CAPACITY];
    logic signed [VALUE_W-1:0] entries_next [CAPACITY];

    logic [CMP_W-1:0]          idx_w;
    logic [CMP_W-1:0]          cnt_w;
    logic [CMP_W-1:0]          pos;
    logic                      full;
    logic                      empty;
    logic                      do_ins;
    logic                      do_rem;
    logic [STAT_W-1:0]         status_c;
    logic signed [VALUE_W-1:0] rd_c;
    logic signed [VALUE_W-1:0] rd_mux;

    assign idx_w = CMP_W'(item_reg.index);
    assign cnt_w = CMP_W'(count_reg);
    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);

    // read port: select the entry at the held index
    always_comb
    begin
        rd_mux = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (idx_w == CMP_W'(i))
            begin
                rd_mux = entries_reg[i];
            end
        end
    end

    // decode the held command into position, operation and status
    always_comb
    begin
        status_c = ST_OK;
        rd_c     = '0;
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        pos      = '0;
        case (item_reg.command)
            CMD_INS_FRONT:
            begin
                if (full) status_c = ST_FULL;
                else      do_ins   = 1'b1;
            end
            CMD_INS_BACK:
            begin
                pos = cnt_w;
                if (full) status_c = ST_FULL;
                else      do_ins   = 1'b1;
            end
            CMD_INS_AT:
            begin
                pos = idx_w;
                if (idx_w > cnt_w) status_c = ST_RANGE;
                else if (full)     status_c = ST_FULL;
                else               do_ins   = 1'b1;
            end
            CMD_REM_FRONT:
            begin
                if (empty) status_c = ST_EMPTY;
                else       do_rem   = 1'b1;
            end
            CMD_REM_BACK:
            begin
                pos = cnt_w - CMP_W'(1);
                if (empty) status_c = ST_EMPTY;
                else       do_rem   = 1'b1;
            end
            CMD_REM_AT:
            begin
                pos = idx_w;
                if (empty)               status_c = ST_EMPTY;
                else if (idx_w >= cnt_w) status_c = ST_RANGE;
                else                     do_rem   = 1'b1;
            end
            CMD_READ:
            begin
                if (empty)               status_c = ST_EMPTY;
                else if (idx_w >= cnt_w) status_c = ST_RANGE;
                else                     rd_c     = rd_mux;
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)      count_next = count_reg + CW'(1);
        else if (do_rem) count_next = count_reg - CW'(1);
    end

    // per-entry shift: up from the position on insert, down after it on removal
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_entry
        localparam logic [CMP_W-1:0] I_W  = CMP_W'(i);
        localparam logic [CMP_W-1:0] I1_W = CMP_W'(i + 1);
        always_comb
        begin
            entries_next[i] = entries_reg[i];
            if (do_ins)
            begin
                if (I_W == pos)
                begin
                    entries_next[i] = item_reg.value;
                end
                else if (I_W > pos && I_W <= cnt_w)
                begin
                    if (i > 0) entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_rem)
            begin
                if (I_W >= pos && I1_W < cnt_w)
                begin
                    if (i < CAPACITY - 1)
                        entries_next[i] = entries_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            item_reg <= cmd_item;
        end
        if (ctrl.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
            rsp_reg.status      <= status_c;
            rsp_reg.read_value  <= rd_c;
            rsp_reg.entry_count <= COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign rsp_item = rsp_reg;

endmodule
